### design/cb16_pkg.sv
// Shared types, constants and small tables of the CJK base-16384 encoder.
package cb16_pkg;

   // Symbol coding constants.
   localparam int unsigned SymBits    = 14;
   localparam int unsigned GroupBytes = 7;
   localparam int unsigned GroupBits  = GroupBytes * 8;
   localparam int unsigned HeldBits   = (GroupBytes - 1) * 8;
   localparam int unsigned SymsPerGrp = GroupBits / SymBits;
   localparam logic [13:0] SymMask    = 14'h3FFF;
   localparam logic [15:0] SymBase    = 16'h4E01;
   localparam logic [15:0] PadCode    = 16'h4E00;

   // Job queue between the front and back parts.
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QPtrBits   = $clog2(QueueDepth);
   localparam int unsigned QCntBits   = $clog2(QueueDepth + 1);

   // One group handed from the front to the back part.
   typedef struct packed {
      logic [GroupBits-1:0] group;     // little-endian bytes, zero padded
      logic [2:0]           n_bytes;   // 1..7 bytes present
      logic [2:0]           n_syms;    // 1..4 symbols to emit
      logic                 fin;       // group closes the message
   } job_type;

   // Number of symbols produced by a group of n bytes (a full group gives four).
   function automatic logic [2:0] syms_for_bytes(input logic [2:0] n);
      logic [2:0] r;
      begin
         unique case (n)
            3'd1:    r = 3'd1;
            3'd2:    r = 3'd2;
            3'd3:    r = 3'd2;
            3'd4:    r = 3'd3;
            3'd5:    r = 3'd3;
            3'd6:    r = 3'd4;
            3'd7:    r = 3'd4;
            default: r = 3'd1;
         endcase
         return r;
      end
   endfunction

   // Byte index in which a symbol starts: idx*14/8.
   function automatic logic [2:0] sym_start_byte(input logic [1:0] idx);
      logic [2:0] r;
      begin
         unique case (idx)
            2'd0: r = 3'd0;
            2'd1: r = 3'd1;
            2'd2: r = 3'd3;
            2'd3: r = 3'd5;
         endcase
         return r;
      end
   endfunction

endpackage

### design/cb16_front.sv
// Front part: packs incoming bytes into groups of seven and issues encode jobs.
module cb16_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [7:0]      req_data_byte,
   input  logic            req_final_byte,
   output logic            job_valid,
   input  logic            job_ready,
   output cb16_pkg::job_type job
);
   import cb16_pkg::*;

   logic [HeldBits-1:0]  held_bytes_ff, held_bytes_in;
   logic [2:0]           held_count_ff, held_count_in;
   logic [GroupBits-1:0] group;
   logic [GroupBits-1:0] held_ext;
   logic [2:0]           n_bytes;
   logic                 accept;
   logic                 close_group;

   // A word is taken whenever the queue has room for a job.
   assign req_ready = job_ready;
   assign accept    = req_valid && req_ready;

   // Drop the new byte into its lane of the group.
   assign held_ext = {8'h00, held_bytes_ff};
   always_comb begin
      for (int k = 0; k < GroupBytes; k++) begin
         group[8*k +: 8] = (held_count_ff == 3'(k)) ? req_data_byte : held_ext[8*k +: 8];
      end
   end

   assign n_bytes     = held_count_ff + 3'd1;
   assign close_group = (n_bytes == 3'(GroupBytes)) || req_final_byte;

   // Job issued on a full group or on the final byte.
   assign job_valid   = accept && close_group;
   assign job.group   = group;
   assign job.n_bytes = n_bytes;
   assign job.n_syms  = syms_for_bytes(n_bytes);
   assign job.fin     = req_final_byte;

   // Next holding state.
   always_comb begin
      held_bytes_in = held_bytes_ff;
      held_count_in = held_count_ff;
      if (accept) begin
         if (close_group) begin
            held_bytes_in = '0;
            held_count_in = 3'd0;
         end else begin
            held_bytes_in = group[HeldBits-1:0];
            held_count_in = n_bytes;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_bytes_ff <= '0;
         held_count_ff <= 3'd0;
      end else begin
         held_bytes_ff <= held_bytes_in;
         held_count_ff <= held_count_in;
      end
   end

   // At most six bytes are ever held between groups.
   a_held_count_range: assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= 3'd6)
      else $error("front holds more than six bytes");

endmodule

### design/cb16_queue.sv
// Short job queue that decouples the front part from the back part.
module cb16_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  cb16_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output cb16_pkg::job_type pop_job
);
   import cb16_pkg::*;

   job_type             entry_ff [QueueDepth];
   logic [QPtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntBits-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != QCntBits'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPtrBits'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPtrBits'(1) : rd_ptr_ff;
      count_in  = count_ff + QCntBits'(do_push) - QCntBits'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Fill level stays within the depth, and pointers agree with it.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCntBits'(QueueDepth))
      else $error("job queue overfilled");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[QPtrBits-1:0])
      else $error("queue pointers disagree with fill level");

endmodule

### design/cb16_back.sv
// Back part: emits one code point per cycle from the job at the queue head while the output is not stalled.
module cb16_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  cb16_pkg::job_type job,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [15:0]       rsp_code_point,
   output logic              rsp_last_of_run,
   output logic              rsp_end_of_message
);
   import cb16_pkg::*;

   logic [1:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] code_ff;
   logic        last_ff;
   logic        end_ff;
   logic [13:0] sym;
   logic [15:0] code;
   logic        is_last;
   logic        load;
   logic        real_zero;

   // Pick the current symbol and decide between a coded zero and padding.
   assign sym       = job.group[SymBits*idx_ff +: SymBits] & SymMask;
   assign real_zero = ({1'b0, sym_start_byte(idx_ff)} + 4'd1) < {1'b0, job.n_bytes};
   assign code      = (sym != '0) ? ({2'b00, sym} + SymBase)
                                  : (real_zero ? SymBase : PadCode);
   assign is_last   = ({1'b0, idx_ff} + 3'd1) == job.n_syms;

   // The output register loads when empty or when its word is being taken.
   assign load      = job_valid && (!rsp_valid_ff || rsp_ready);
   assign job_ready = load && is_last;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         idx_in       = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output word payload.
   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= code;
         last_ff <= is_last;
         end_ff  <= is_last && job.fin;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_code_point     = code_ff;
   assign rsp_last_of_run    = last_ff;
   assign rsp_end_of_message = end_ff;

   // The message end always closes a run.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_message |-> rsp_last_of_run)
      else $error("end of message without end of run");

   // The symbol index never runs past the job's symbol count.
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> ({1'b0, idx_ff} < job.n_syms))
      else $error("symbol index beyond job length");

endmodule

### design/cjk_base16384_encoder.sv
// Top level of the CJK base-16384 encoder: front packer, job queue and symbol emitter.
//
//  Channel   Direction  Handshake               Word
//  req_      in         req_valid / req_ready   data byte, final flag
//  rsp_      out        rsp_valid / rsp_ready   code point, run end, message end
//
// A byte is taken every cycle while the four-entry job queue has room.
// Each full group of seven bytes, or the final byte, becomes one job of one to four
// symbols; the emitter sends one code point per cycle while rsp_ready is high, so
// its single output register sets the rate: four code points per group of seven bytes.
// The closing byte's job passes through a queue entry, then the output register.
// Synchronous reset empties the queue and clears the held bytes; a stalled
// output fills the queue, after which req_ready falls.
module cjk_base16384_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_point,
   output logic        rsp_last_of_run,
   output logic        rsp_end_of_message
);
   import cb16_pkg::*;

   job_type front_job;
   job_type head_job;
   logic    front_valid;
   logic    front_ready;
   logic    head_valid;
   logic    head_ready;

   // Byte packing.
   cb16_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .job_valid      (front_valid),
      .job_ready      (front_ready),
      .job            (front_job)
   );

   // Job queue.
   cb16_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_job   (front_job),
      .pop_valid  (head_valid),
      .pop_ready  (head_ready),
      .pop_job    (head_job)
   );

   // Symbol emission.
   cb16_back u_back (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (head_valid),
      .job_ready          (head_ready),
      .job                (head_job),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_code_point     (rsp_code_point),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_end_of_message (rsp_end_of_message)
   );

endmodule

### tb/sv/cjk_base16384_encoder_tb.sv
// Self-checking testbench of the CJK base-16384 encoder: byte stimulus, code point checking.
module cjk_base16384_encoder_tb;
   import cb16_pkg::*;

   // One expected output word of the result channel.
   typedef struct packed {
      logic [15:0] code_point;
      logic        last_of_run;
      logic        end_of_message;
   } code_word_type;

   // Packs bytes into groups as the block does and keeps the code points still owed.
   class code_point_board;
      logic [47:0]   held_bytes;
      logic [2:0]    held_count;
      code_word_type owed_words[$];
      int            mismatches;

      function new();
         held_bytes = '0;
         held_count = '0;
         mismatches = 0;
      endfunction

      // Work out the words that an accepted input word causes.
      function void absorb_byte(input logic [7:0] data_byte, input logic final_byte);
         logic [55:0]   group;
         logic [13:0]   sym;
         int            n;
         int            n_syms;
         code_word_type w;
         group = {8'h00, held_bytes} | ({48'h0, data_byte} << (8 * held_count));
         n = held_count + 1;
         if (n == GroupBytes) begin
            // A full group gives four symbols, zero symbols included, with no padding.
            for (int i = 0; i < 4; i++) begin
               sym = 14'((group >> (SymBits * i)) & 56'(SymMask));
               w.code_point     = {2'b00, sym} + SymBase;
               w.last_of_run    = (i == 3);
               w.end_of_message = final_byte && (i == 3);
               owed_words = {owed_words, w};
            end
            held_bytes = '0;
            held_count = '0;
         end else if (final_byte) begin
            // A partial tail: zero symbols past the last real byte become padding.
            n_syms = n * 8 / SymBits + 1;
            for (int i = 0; i < n_syms; i++) begin
               sym = 14'((group >> (SymBits * i)) & 56'(SymMask));
               if (sym != 14'h0)
                  w.code_point = {2'b00, sym} + SymBase;
               else if (i * SymBits / 8 + 1 < n)
                  w.code_point = SymBase;
               else
                  w.code_point = PadCode;
               w.last_of_run    = (i + 1 == n_syms);
               w.end_of_message = (i + 1 == n_syms);
               owed_words = {owed_words, w};
            end
            held_bytes = '0;
            held_count = '0;
         end else begin
            held_bytes = group[47:0];
            held_count = 3'(n);
         end
      endfunction

      // Compare an accepted output word with the oldest one owed.
      function void compare_word(input logic [15:0] code_point, input logic last_of_run,
                                 input logic end_of_message);
         code_word_type w;
         if (owed_words.size() == 0) begin
            $error("unexpected word: code_point %h", code_point);
            mismatches++;
         end else begin
            w = owed_words.pop_front();
            if (code_point !== w.code_point) begin
               $error("code_point expected %h actual %h", w.code_point, code_point);
               mismatches++;
            end
            if (last_of_run !== w.last_of_run) begin
               $error("last_of_run expected %b actual %b", w.last_of_run, last_of_run);
               mismatches++;
            end
            if (end_of_message !== w.end_of_message) begin
               $error("end_of_message expected %b actual %b", w.end_of_message,
                      end_of_message);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_final_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_code_point;
   logic        rsp_last_of_run;
   logic        rsp_end_of_message;

   // Set in the last part of the run: neither side idles.
   bit              steady_phase;
   code_point_board board;

   cjk_base16384_encoder i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_final_byte     (req_final_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_code_point     (rsp_code_point),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_end_of_message (rsp_end_of_message)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard limit on the length of the run.
   initial begin
      #400000;
      $display("*** FAILED ***");
      $finish;
   end

   // Receiver: ready held low in random bursts.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!steady_phase && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   // Output monitor: every accepted word is checked.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.compare_word(rsp_code_point, rsp_last_of_run, rsp_end_of_message);
   end

   // Offer one input word, with a random gap before it, and wait for acceptance.
   task automatic send_byte(input logic [7:0] data_byte, input logic final_byte);
      int gap;
      if (!steady_phase && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= data_byte;
      req_final_byte <= final_byte;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.absorb_byte(data_byte, final_byte);
      @(negedge clock);
   endtask

   // A whole message: fill 0 gives zero bytes, 1 gives all ones, 2 gives random bytes
   // with many zeros, so that zero symbols turn up in tails and full groups.
   task automatic send_message(input int length, input int fill);
      logic [7:0] data_byte;
      for (int k = 0; k < length; k++) begin
         case (fill)
            0:       data_byte = 8'h00;
            1:       data_byte = 8'hFF;
            default: data_byte = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
         endcase
         send_byte(data_byte, k == length - 1);
      end
   endtask

   // Stimulus and end of run.
   initial begin
      int sent;
      int length;
      int waited;
      board          = new();
      steady_phase   = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = 8'h00;
      req_final_byte = 1'b0;
      repeat (5) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed messages: single zero byte as pure padding, short zero tails, a tail of
      // six zero bytes that mixes zero symbols and padding, a full zero group closing
      // the message, an all-ones tail and a short mixed message.
      send_message(1, 0);
      send_message(2, 0);
      send_message(6, 0);
      send_message(7, 0);
      send_message(6, 1);
      send_message(3, 2);

      // Random messages, mostly short, a few long enough for several groups.
      sent = 0;
      while (sent < 300) begin
         if ($urandom_range(0, 7) == 0)
            length = $urandom_range(15, 40);
         else
            length = $urandom_range(1, 14);
         if (sent > 240)
            steady_phase = 1'b1;
         send_message(length, 2);
         sent += length;
      end
      req_valid <= 1'b0;

      // Drain the outstanding words, then keep watching for strays.
      waited = 0;
      while (board.owed_words.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (board.owed_words.size() != 0) begin
         $error("%0d words never arrived", board.owed_words.size());
         board.mismatches++;
      end
      if (board.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
